### sv/chd_pkg.sv
`default_nettype none

package chd_pkg;

    // Grid geometry.
    localparam int GRID_W = 64;
    localparam int GRID_H = 32;
    localparam int CELLS  = GRID_W * GRID_H;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int X_W    = $clog2(GRID_W);
    localparam int Y_W    = $clog2(GRID_H);

    // Fixed widths of the item fields.
    localparam int CELL_X_W = 6;
    localparam int CELL_Y_W = 5;
    localparam int TEMP_W   = 8;

    localparam int MAX_PASSES = 8;
    localparam int PASS_W     = $clog2(MAX_PASSES);

    // Operation codes.
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_REPORT = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAVA       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLD_FLOOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PASSES     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_ROW  = 3'd4;
    localparam int CFG_DATA_W = 8;

    typedef struct packed {
        logic [TEMP_W-1:0] ambient;
        logic [TEMP_W-1:0] lava;
        logic [TEMP_W-1:0] cold_floor;
        logic [3:0]        passes;
        logic [5:0]        first_row;
    } cfg_t;

    typedef struct packed {
        logic [1:0]          operation;
        logic [CELL_X_W-1:0] cell_x;
        logic [CELL_Y_W-1:0] cell_y;
        logic                has_lava;
        logic                has_water;
        logic                all_wall;
    } item_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [TEMP_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr0;
        logic [ADDR_W-1:0] raddr1;
    } mem_req_t;

endpackage

`default_nettype wire

### sv/chd_store.sv
`default_nettype none

// Temperature store: one write port and two read ports, read data registered.
module chd_store (
    input  wire logic                          aclk,
    input  wire chd_pkg::mem_req_t             mem_req,
    output logic     [chd_pkg::TEMP_W-1:0]     rd_data0,
    output logic     [chd_pkg::TEMP_W-1:0]     rd_data1
);

    logic [chd_pkg::TEMP_W-1:0] mem [chd_pkg::CELLS];
    logic [chd_pkg::TEMP_W-1:0] rd0_reg;
    logic [chd_pkg::TEMP_W-1:0] rd1_reg;

    always_ff @(posedge aclk) begin
        if (mem_req.we) begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        rd0_reg <= mem[mem_req.raddr0];
        rd1_reg <= mem[mem_req.raddr1];
    end

    assign rd_data0 = rd0_reg;
    assign rd_data1 = rd1_reg;

endmodule

`default_nettype wire

### sv/chd_engine.sv
`default_nettype none

// Sequencer and datapath: clearing sweep, stencil passes, pin sweep, tile reports and reads
// on the store; stencil passes and tile reports are read-modify-write.
module chd_engine (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire chd_pkg::cfg_t                 cfg,
    input  wire logic                          in_accept,
    input  wire chd_pkg::item_t                in_item,
    output logic                               idle,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output logic     [chd_pkg::TEMP_W-1:0]     res_data,
    output chd_pkg::mem_req_t                  mem_req,
    input  wire logic [chd_pkg::TEMP_W-1:0]    rd_data0,
    input  wire logic [chd_pkg::TEMP_W-1:0]    rd_data1
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FILL   = 3'd1;
    localparam logic [2:0] ST_TICK_A = 3'd2;
    localparam logic [2:0] ST_TICK_B = 3'd3;
    localparam logic [2:0] ST_RMW    = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    function automatic logic [chd_pkg::ADDR_W-1:0] cell_addr(input int y, input int x);
        cell_addr = chd_pkg::ADDR_W'(y * chd_pkg::GRID_W + x);
    endfunction

    // (4*t + l + r + u + d) >> 3, then one step toward ambient on the last pass.
    function automatic logic [chd_pkg::TEMP_W-1:0] stencil(
        input logic [chd_pkg::TEMP_W-1:0] t,
        input logic [chd_pkg::TEMP_W-1:0] l,
        input logic [chd_pkg::TEMP_W-1:0] r,
        input logic [chd_pkg::TEMP_W-1:0] u,
        input logic [chd_pkg::TEMP_W-1:0] d,
        input logic                       last,
        input logic [chd_pkg::TEMP_W-1:0] amb
    );
        logic [chd_pkg::TEMP_W+2:0] sum;
        logic [chd_pkg::TEMP_W-1:0] v;
        sum = {1'b0, t, 2'b00} + (chd_pkg::TEMP_W+3)'(l) + (chd_pkg::TEMP_W+3)'(r)
            + (chd_pkg::TEMP_W+3)'(u) + (chd_pkg::TEMP_W+3)'(d);
        v = sum[chd_pkg::TEMP_W+2:3];
        if (last && (v > amb)) begin
            v = v - 1'b1;
        end else if (last && (v < amb)) begin
            v = v + 1'b1;
        end
        stencil = v;
    endfunction

    logic [2:0]                   state_reg, state_next;
    logic [chd_pkg::X_W-1:0]      x_reg, x_next;
    logic [chd_pkg::Y_W-1:0]      y_reg, y_next;
    logic                         done_reg, done_next;
    logic                         pend_reg, pend_next;
    logic [chd_pkg::ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic                         pend_x0_reg, pend_x0_next;
    logic [chd_pkg::TEMP_W-1:0]   up_reg, up_next;
    logic [chd_pkg::TEMP_W-1:0]   dn_reg, dn_next;
    logic [chd_pkg::TEMP_W-1:0]   left_reg, left_next;
    logic [chd_pkg::PASS_W-1:0]   pass_reg, pass_next;
    logic [chd_pkg::ADDR_W-1:0]   fill_addr_reg, fill_addr_next;
    logic                         fill_tick_reg, fill_tick_next;
    chd_pkg::item_t               item_reg, item_next;
    logic [chd_pkg::ADDR_W-1:0]   item_addr_reg, item_addr_next;
    logic                         item_in_reg, item_in_next;
    logic                         item_wr_ok_reg, item_wr_ok_next;
    logic [chd_pkg::TEMP_W-1:0]   result_reg, result_next;

    logic [chd_pkg::ADDR_W-1:0]   cur_addr;
    logic [chd_pkg::ADDR_W-1:0]   up_addr;
    logic [chd_pkg::ADDR_W-1:0]   dn_addr;
    logic [chd_pkg::ADDR_W-1:0]   right_addr;
    logic [3:0]                   n_passes;
    logic                         last_pass;
    logic                         in_grid;
    logic [chd_pkg::TEMP_W-1:0]   cell_new;
    logic [chd_pkg::TEMP_W-1:0]   rpt_val;

    always_comb begin
        cur_addr   = cell_addr(int'(y_reg), int'(x_reg));
        up_addr    = (y_reg == '0) ? cur_addr : cur_addr - chd_pkg::ADDR_W'(chd_pkg::GRID_W);
        dn_addr    = (int'(y_reg) == chd_pkg::GRID_H - 1) ? cur_addr
                   : cur_addr + chd_pkg::ADDR_W'(chd_pkg::GRID_W);
        right_addr = (int'(x_reg) == chd_pkg::GRID_W - 1) ? cur_addr
                   : cur_addr + chd_pkg::ADDR_W'(1);

        if (cfg.passes == 4'd0) begin
            n_passes = 4'd1;
        end else if (int'(cfg.passes) > chd_pkg::MAX_PASSES) begin
            n_passes = 4'(chd_pkg::MAX_PASSES);
        end else begin
            n_passes = cfg.passes;
        end
        last_pass = ((4'(pass_reg) + 4'd1) == n_passes);

        in_grid = (int'(in_item.cell_x) < chd_pkg::GRID_W)
               && (int'(in_item.cell_y) < chd_pkg::GRID_H);

        // At the start of a row the left neighbor is the cell itself.
        cell_new = stencil(rd_data0, pend_x0_reg ? rd_data0 : left_reg, rd_data1,
                           up_reg, dn_reg, last_pass, cfg.ambient);

        if (item_reg.has_lava) begin
            rpt_val = cfg.lava;
        end else if (item_reg.all_wall) begin
            rpt_val = cfg.ambient;
        end else if (item_reg.has_water && (rd_data0 > cfg.cold_floor)) begin
            rpt_val = rd_data0 - 1'b1;
        end else begin
            rpt_val = rd_data0;
        end
    end

    always_comb begin
        state_next      = state_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        done_next       = done_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        pend_x0_next    = pend_x0_reg;
        up_next         = up_reg;
        dn_next         = dn_reg;
        left_next       = left_reg;
        pass_next       = pass_reg;
        fill_addr_next  = fill_addr_reg;
        fill_tick_next  = fill_tick_reg;
        item_next       = item_reg;
        item_addr_next  = item_addr_reg;
        item_in_next    = item_in_reg;
        item_wr_ok_next = item_wr_ok_reg;
        result_next     = result_reg;
        mem_req         = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    item_next       = in_item;
                    item_in_next    = in_grid;
                    item_addr_next  = in_grid ? cell_addr(int'(in_item.cell_y),
                                                          int'(in_item.cell_x)) : '0;
                    item_wr_ok_next = in_grid && ({1'b0, in_item.cell_y} < cfg.first_row);
                    result_next     = '0;
                    mem_req.raddr0  = item_addr_next;
                    case (in_item.operation)
                        chd_pkg::OP_TICK: begin
                            x_next    = '0;
                            y_next    = '0;
                            done_next = 1'b0;
                            pend_next = 1'b0;
                            pass_next = '0;
                            state_next = ST_TICK_A;
                        end
                        chd_pkg::OP_REPORT, chd_pkg::OP_READ: begin
                            state_next = ST_RMW;
                        end
                        default: begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_TICK_A: begin
                // Retire the cell whose center and right values arrive now.
                if (pend_reg) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pend_addr_reg;
                    mem_req.wdata = cell_new;
                    left_next     = cell_new;
                end
                pend_next = 1'b0;
                if (!done_reg) begin
                    mem_req.raddr0 = up_addr;
                    mem_req.raddr1 = dn_addr;
                    state_next     = ST_TICK_B;
                end else if (last_pass) begin
                    if (int'(cfg.first_row) < chd_pkg::GRID_H) begin
                        fill_addr_next = cell_addr(int'(cfg.first_row), 0);
                        fill_tick_next = 1'b1;
                        state_next     = ST_FILL;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end else begin
                    pass_next = pass_reg + 1'b1;
                    x_next    = '0;
                    y_next    = '0;
                    done_next = 1'b0;
                end
            end
            ST_TICK_B: begin
                up_next        = rd_data0;
                dn_next        = rd_data1;
                mem_req.raddr0 = cur_addr;
                mem_req.raddr1 = right_addr;
                pend_next      = 1'b1;
                pend_addr_next = cur_addr;
                pend_x0_next   = (x_reg == '0);
                if (int'(x_reg) == chd_pkg::GRID_W - 1) begin
                    x_next = '0;
                    if (int'(y_reg) == chd_pkg::GRID_H - 1) begin
                        done_next = 1'b1;
                    end else begin
                        y_next = y_reg + 1'b1;
                    end
                end else begin
                    x_next = x_reg + 1'b1;
                end
                state_next = ST_TICK_A;
            end
            ST_RMW: begin
                if (item_reg.operation == chd_pkg::OP_REPORT) begin
                    mem_req.we    = item_wr_ok_reg;
                    mem_req.waddr = item_addr_reg;
                    mem_req.wdata = rpt_val;
                end else begin
                    result_next = item_in_reg ? rd_data0 : '0;
                end
                state_next = ST_RESULT;
            end
            ST_FILL: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = fill_addr_reg;
                mem_req.wdata = fill_tick_reg ? cfg.ambient : '0;
                if (int'(fill_addr_reg) == chd_pkg::CELLS - 1) begin
                    state_next = fill_tick_reg ? ST_RESULT : ST_IDLE;
                end else begin
                    fill_addr_next = fill_addr_reg + 1'b1;
                end
            end
            ST_RESULT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FILL;
            fill_addr_reg <= '0;
            fill_tick_reg <= 1'b0;
            pend_reg      <= 1'b0;
            done_reg      <= 1'b0;
            pass_reg      <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
        end else begin
            state_reg     <= state_next;
            fill_addr_reg <= fill_addr_next;
            fill_tick_reg <= fill_tick_next;
            pend_reg      <= pend_next;
            done_reg      <= done_next;
            pass_reg      <= pass_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg  <= pend_addr_next;
        pend_x0_reg    <= pend_x0_next;
        up_reg         <= up_next;
        dn_reg         <= dn_next;
        left_reg       <= left_next;
        item_reg       <= item_next;
        item_addr_reg  <= item_addr_next;
        item_in_reg    <= item_in_next;
        item_wr_ok_reg <= item_wr_ok_next;
        result_reg     <= result_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESULT);
    assign res_data  = result_reg;

endmodule

`default_nettype wire

### sv/coarse_heat_diffusion_grid.sv
`default_nettype none

// Channel  Dir  Ports                      Payload
// s_       in   s_tvalid/s_tready/s_tdata  cell_x, cell_y, has_lava, has_water, all_wall
//               s_tuser                    operation
// m_       out  m_tvalid/m_tready/m_tdata  cell_temp
// cfg_     in   cfg_wr_en/cfg_index/cfg_wdata  register index and value
//
// After reset the store is swept to zero; s_tready stays low meanwhile.
// A tile report or a read first reads its cell through the store's registered read
// port, then writes the cell back (report) or captures its value (read).
// A tick reads each cell in two steps on the two store read ports (up/down, then
// center/right) in every pass, then sets the pinned rows, first_row onward, to ambient.
// One item is worked on at a time; the result register lets the next item be taken while
// a result still waits on m_tready.
module coarse_heat_diffusion_grid (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [5:0] cell_x, [10:6] cell_y, [11] has_lava, [12] has_water, [13] all_wall,
    // [15:14] zero
    input  wire logic [15:0]                         s_tdata,
    // [1:0] operation
    input  wire logic [1:0]                          s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [7:0] cell_temp
    output logic      [7:0]                          m_tdata,
    input  wire logic                                cfg_wr_en,
    input  wire logic [chd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [chd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    chd_pkg::cfg_t     cfg_reg, cfg_next;
    chd_pkg::item_t    in_item;
    chd_pkg::mem_req_t mem_req;

    logic                         eng_idle;
    logic                         res_valid;
    logic                         res_ready;
    logic [chd_pkg::TEMP_W-1:0]   res_data;
    logic [chd_pkg::TEMP_W-1:0]   rd_data0;
    logic [chd_pkg::TEMP_W-1:0]   rd_data1;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [chd_pkg::TEMP_W-1:0]   m_tdata_reg, m_tdata_next;

    // Unpack the input transfer into its fields.
    always_comb begin
        in_item.operation = s_tuser;
        in_item.cell_x    = s_tdata[5:0];
        in_item.cell_y    = s_tdata[10:6];
        in_item.has_lava  = s_tdata[11];
        in_item.has_water = s_tdata[12];
        in_item.all_wall  = s_tdata[13];
    end

    // Configuration writes. Indexes past the list are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                chd_pkg::REG_AMBIENT:    cfg_next.ambient    = cfg_wdata;
                chd_pkg::REG_LAVA:       cfg_next.lava       = cfg_wdata;
                chd_pkg::REG_COLD_FLOOR: cfg_next.cold_floor = cfg_wdata;
                chd_pkg::REG_PASSES:     cfg_next.passes     = cfg_wdata[3:0];
                chd_pkg::REG_FIRST_ROW:  cfg_next.first_row  = cfg_wdata[5:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ambient    <= 8'd128;
            cfg_reg.lava       <= 8'd255;
            cfg_reg.cold_floor <= 8'd0;
            cfg_reg.passes     <= 4'd2;
            cfg_reg.first_row  <= 6'd32;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_tready = eng_idle;

    chd_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_accept (s_tvalid && eng_idle),
        .in_item   (in_item),
        .idle      (eng_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .mem_req   (mem_req),
        .rd_data0  (rd_data0),
        .rd_data1  (rd_data1)
    );

    chd_store u_store (
        .aclk     (aclk),
        .mem_req  (mem_req),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1)
    );

    // Output register: a finished result moves in whenever the register is empty
    // or its current result is being taken in the same cycle.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = res_data;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

### sv/chd_checker.sv
`default_nettype none

module chd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata
);

    // A held result keeps its value until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The clearing sweep keeps the input closed right after reset.
    assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input open during clearing sweep");

    // Only one item is worked on at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in progress");

    // A tick cannot produce its result in the very next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == chd_pkg::OP_TICK) |=> !$rose(m_tvalid))
        else $error("tick result appeared too early");

endmodule

bind coarse_heat_diffusion_grid chd_checker u_chd_checker (.*);

`default_nettype wire
